/* design/rbd_pkg.sv */
// rbd_pkg: shared sizes, types and codes of the ring buffer deque
// no dependencies; used by ring_buffer_deque, its checker and its testbench
package rbd_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_REAR  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_HEAD   = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_INDEX = 3'd4,
        REQ_CLEAR      = 3'd5,
        REQ_RESIZE     = 3'd6,
        REQ_NONE       = 3'd7
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BIG   = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_RD_IDX,
        S_RD_FRONT,
        S_RD_BACK,
        S_TAKE_BACK,
        S_LOAD
    } state_t;

endpackage

/* design/ring_buffer_deque.sv */
// ring_buffer_deque: double-ended queue held in a 64 x 32 ring memory
// depends on rbd_pkg
//
// One request is taken at a time; a result waits in its own output register, so the next
// request is accepted while it is still pending. Push, pop, clear, read out of range and a
// resize that does not grow go from the update straight to the reads of front and back; an
// in-range read_index first reads the indexed element; a growing resize first writes the new
// slots, one per cycle, from the old count up to new_size. The ring memory has a single read
// port: the indexed element, the front and the back are read from it one after the other.
module ring_buffer_deque
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  req_type,
    input  logic [31:0]                 data_value,
    input  logic [5:0]                  elem_index,
    input  logic [6:0]                  new_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 read_data,
    output logic [31:0]                 front_data,
    output logic [31:0]                 back_data,
    output logic [6:0]                  elem_count,
    output logic [1:0]                  status
);

    rbd_pkg::data_t  ring_mem [rbd_pkg::DEPTH];
    rbd_pkg::data_t  mem_rdata_reg;
    rbd_pkg::ptr_t   mem_raddr;
    rbd_pkg::ptr_t   mem_waddr;
    logic            mem_we;

    rbd_pkg::state_t state_reg, state_next;
    rbd_pkg::req_t   req_reg;
    rbd_pkg::data_t  val_reg;
    rbd_pkg::ptr_t   idx_reg;
    rbd_pkg::cnt_t   nsz_reg;

    rbd_pkg::ptr_t   head_reg, head_next;
    rbd_pkg::cnt_t   occ_reg, occ_next;
    rbd_pkg::cnt_t   fill_reg, fill_next;
    rbd_pkg::stat_t  status_reg, status_next;
    logic            rd_ok_reg, rd_ok_next;
    rbd_pkg::data_t  rd_data_reg, rd_data_next;
    rbd_pkg::data_t  front_reg, front_next;
    rbd_pkg::data_t  back_reg, back_next;

    logic            out_valid_reg;
    rbd_pkg::data_t  out_read_reg, out_front_reg, out_back_reg;
    rbd_pkg::cnt_t   out_count_reg;
    rbd_pkg::stat_t  out_status_reg;

    logic            accept;
    logic            out_load;
    logic            is_full, is_empty, idx_ok, grow;
    rbd_pkg::ptr_t   back_slot;

    assign accept    = in_valid && in_ready;
    assign is_full   = (occ_reg == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign is_empty  = (occ_reg == '0);
    assign idx_ok    = (rbd_pkg::CNT_W'(idx_reg) < occ_reg);
    assign grow      = (nsz_reg <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH)) && (nsz_reg > occ_reg);
    assign back_slot = is_empty ? head_reg
                     : rbd_pkg::PTR_W'(head_reg + occ_reg[rbd_pkg::PTR_W-1:0] - 1'b1);

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= val_reg;
        end
        mem_rdata_reg <= ring_mem[mem_raddr];
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= rbd_pkg::req_t'(req_type);
            val_reg <= data_value;
            idx_reg <= elem_index;
            nsz_reg <= new_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbd_pkg::S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg    <= fill_next;
        status_reg  <= status_next;
        rd_ok_reg   <= rd_ok_next;
        rd_data_reg <= rd_data_next;
        front_reg   <= front_next;
        back_reg    <= back_next;
        if (out_load)
        begin
            out_read_reg   <= rd_ok_reg ? rd_data_reg : '0;
            out_front_reg  <= is_empty ? '0 : front_reg;
            out_back_reg   <= is_empty ? '0 : back_reg;
            out_count_reg  <= occ_reg;
            out_status_reg <= status_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rbd_pkg::S_EXEC;
                end
            end
            rbd_pkg::S_EXEC:
            begin
                if (req_reg == rbd_pkg::REQ_RESIZE && grow)
                begin
                    state_next = rbd_pkg::S_FILL;
                end
                else if (req_reg == rbd_pkg::REQ_READ_INDEX && idx_ok)
                begin
                    state_next = rbd_pkg::S_RD_IDX;
                end
                else
                begin
                    state_next = rbd_pkg::S_RD_FRONT;
                end
            end
            rbd_pkg::S_FILL:
            begin
                if (fill_reg == rbd_pkg::CNT_W'(occ_reg - 1'b1))
                begin
                    state_next = rbd_pkg::S_RD_FRONT;
                end
            end
            rbd_pkg::S_RD_IDX:    state_next = rbd_pkg::S_RD_FRONT;
            rbd_pkg::S_RD_FRONT:  state_next = rbd_pkg::S_RD_BACK;
            rbd_pkg::S_RD_BACK:   state_next = rbd_pkg::S_TAKE_BACK;
            rbd_pkg::S_TAKE_BACK: state_next = rbd_pkg::S_LOAD;
            rbd_pkg::S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = rbd_pkg::S_IDLE;
                end
            end
            default:              state_next = rbd_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = head_reg;
        mem_raddr    = head_reg;
        head_next    = head_reg;
        occ_next     = occ_reg;
        fill_next    = fill_reg;
        status_next  = status_reg;
        rd_ok_next   = rd_ok_reg;
        rd_data_next = rd_data_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        case (state_reg)
            rbd_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                status_next  = rbd_pkg::ST_OK;
                rd_ok_next   = 1'b0;
                rd_data_next = '0;
            end
            rbd_pkg::S_EXEC:
            begin
                case (req_reg)
                    rbd_pkg::REQ_PUSH_REAR:
                    begin
                        if (is_full)
                        begin
                            status_next = rbd_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rbd_pkg::PTR_W'(head_reg + occ_reg[rbd_pkg::PTR_W-1:0]);
                            occ_next  = rbd_pkg::CNT_W'(occ_reg + 1'b1);
                        end
                    end
                    rbd_pkg::REQ_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = rbd_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rbd_pkg::PTR_W'(head_reg - 1'b1);
                            head_next = rbd_pkg::PTR_W'(head_reg - 1'b1);
                            occ_next  = rbd_pkg::CNT_W'(occ_reg + 1'b1);
                        end
                    end
                    rbd_pkg::REQ_POP_HEAD:
                    begin
                        if (is_empty)
                        begin
                            status_next = rbd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            head_next = rbd_pkg::PTR_W'(head_reg + 1'b1);
                            occ_next  = rbd_pkg::CNT_W'(occ_reg - 1'b1);
                        end
                    end
                    rbd_pkg::REQ_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = rbd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            occ_next = rbd_pkg::CNT_W'(occ_reg - 1'b1);
                        end
                    end
                    rbd_pkg::REQ_READ_INDEX:
                    begin
                        if (idx_ok)
                        begin
                            rd_ok_next = 1'b1;
                        end
                        else
                        begin
                            status_next = rbd_pkg::ST_EMPTY;
                        end
                    end
                    rbd_pkg::REQ_CLEAR:
                    begin
                        head_next = '0;
                        occ_next  = '0;
                    end
                    rbd_pkg::REQ_RESIZE:
                    begin
                        if (nsz_reg > rbd_pkg::CNT_W'(rbd_pkg::DEPTH))
                        begin
                            status_next = rbd_pkg::ST_BIG;
                        end
                        else
                        begin
                            occ_next  = nsz_reg;
                            fill_next = occ_reg;
                        end
                    end
                    default:
                    begin
                        status_next = rbd_pkg::ST_OK;
                    end
                endcase
            end
            rbd_pkg::S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = rbd_pkg::PTR_W'(head_reg + fill_reg[rbd_pkg::PTR_W-1:0]);
                fill_next = rbd_pkg::CNT_W'(fill_reg + 1'b1);
            end
            rbd_pkg::S_RD_IDX:
            begin
                mem_raddr = rbd_pkg::PTR_W'(head_reg + idx_reg);
            end
            rbd_pkg::S_RD_FRONT:
            begin
                mem_raddr = head_reg;
                if (rd_ok_reg)
                begin
                    rd_data_next = mem_rdata_reg;
                end
            end
            rbd_pkg::S_RD_BACK:
            begin
                mem_raddr  = back_slot;
                front_next = mem_rdata_reg;
            end
            rbd_pkg::S_TAKE_BACK:
            begin
                back_next = mem_rdata_reg;
            end
            rbd_pkg::S_LOAD:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_read_reg;
    assign front_data = out_front_reg;
    assign back_data  = out_back_reg;
    assign elem_count = out_count_reg;
    assign status     = out_status_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH))
        else $error("count beyond depth");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == rbd_pkg::S_EXEC || state_reg == rbd_pkg::S_FILL))
        else $error("memory write outside update phase");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == rbd_pkg::S_EXEC)
        else $error("accepted word not executed");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbd_pkg::S_FILL |-> fill_reg < occ_reg)
        else $error("fill past new size");

    a_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && status_reg == rbd_pkg::ST_FULL
        |-> (req_reg == rbd_pkg::REQ_PUSH_REAR || req_reg == rbd_pkg::REQ_PUSH_FRONT))
        else $error("full status on a non-push word");

endmodule

/* tb/sv/ring_buffer_deque_checker.sv */
`timescale 1ns / 100ps
// ring_buffer_deque_checker: watches both channels of the deque, predicts each result
// and compares it field by field; depends on rbd_pkg
module ring_buffer_deque_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [31:0] data_value,
    input  logic [5:0]  elem_index,
    input  logic [6:0]  new_size,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] read_data,
    input  logic [31:0] front_data,
    input  logic [31:0] back_data,
    input  logic [6:0]  elem_count,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          due_count
);

    typedef struct {
        rbd_pkg::data_t rd;
        rbd_pkg::data_t front;
        rbd_pkg::data_t back;
        rbd_pkg::cnt_t  count;
        rbd_pkg::stat_t st;
    } deque_result_t;

    rbd_pkg::data_t slots [rbd_pkg::DEPTH];
    rbd_pkg::ptr_t  head;
    rbd_pkg::cnt_t  fill;
    deque_result_t  due_results [$];
    deque_result_t  want;

    initial
    begin
        foreach (slots[i])
            slots[i] = '0;
    end

    function automatic void apply_request(logic [2:0] code, rbd_pkg::data_t val,
                                          logic [5:0] idx, logic [6:0] nsz);
        deque_result_t res;
        res = '{rd: '0, front: '0, back: '0, count: '0, st: rbd_pkg::ST_OK};
        case (rbd_pkg::req_t'(code))
            rbd_pkg::REQ_PUSH_REAR:
                if (fill >= rbd_pkg::DEPTH)
                    res.st = rbd_pkg::ST_FULL;
                else
                begin
                    slots[rbd_pkg::ptr_t'(head + fill)] = val;
                    fill++;
                end
            rbd_pkg::REQ_PUSH_FRONT:
                if (fill >= rbd_pkg::DEPTH)
                    res.st = rbd_pkg::ST_FULL;
                else
                begin
                    head = rbd_pkg::ptr_t'(head - 1'b1);
                    slots[head] = val;
                    fill++;
                end
            rbd_pkg::REQ_POP_HEAD:
                if (fill == 0)
                    res.st = rbd_pkg::ST_EMPTY;
                else
                begin
                    head = rbd_pkg::ptr_t'(head + 1'b1);
                    fill--;
                end
            rbd_pkg::REQ_POP_BACK:
                if (fill == 0)
                    res.st = rbd_pkg::ST_EMPTY;
                else
                    fill--;
            rbd_pkg::REQ_READ_INDEX:
                if (idx >= fill)
                    res.st = rbd_pkg::ST_EMPTY;
                else
                    res.rd = slots[rbd_pkg::ptr_t'(head + idx)];
            rbd_pkg::REQ_CLEAR:
            begin
                head = '0;
                fill = '0;
            end
            rbd_pkg::REQ_RESIZE:
                if (nsz > rbd_pkg::DEPTH)
                    res.st = rbd_pkg::ST_BIG;
                else
                begin
                    for (int i = fill; i < nsz; i++)
                        slots[rbd_pkg::ptr_t'(head + i)] = val;
                    fill = rbd_pkg::cnt_t'(nsz);
                end
            default:
                ;
        endcase
        if (fill != 0)
        begin
            res.front = slots[head];
            res.back  = slots[rbd_pkg::ptr_t'(head + fill - 1)];
        end
        res.count = fill;
        due_results.insert(due_results.size(), res);
    endfunction

    function automatic void check_field(string what, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val,
                     act_val);
            fail_count++;
        end
    endfunction

    // output side first so a word accepted on the same edge is never matched against itself
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            head       = '0;
            fill       = '0;
            fail_count = 0;
            due_count  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual count %0d status %0d",
                             $time, elem_count, status);
                    fail_count++;
                end
                else
                begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("read_data", want.rd, read_data);
                    check_field("front_data", want.front, front_data);
                    check_field("back_data", want.back, back_data);
                    check_field("elem_count", 32'(want.count), 32'(elem_count));
                    check_field("status", 32'(want.st), 32'(status));
                end
            end
            if (in_valid && in_ready)
                apply_request(req_type, data_value, elem_index, new_size);
            due_count = due_results.size();
        end
    end

endmodule

/* tb/sv/ring_buffer_deque_tb.sv */
`timescale 1ns / 100ps
// ring_buffer_deque_tb: drives request words into the deque with bursty pacing and a
// stalling receiver; depends on rbd_pkg, ring_buffer_deque and ring_buffer_deque_checker
module ring_buffer_deque_tb;

    localparam int RANDOM_WORDS = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [2:0]  req_type   = '0;
    logic [31:0] data_value = '0;
    logic [5:0]  elem_index = '0;
    logic [6:0]  new_size   = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] read_data;
    logic [31:0] front_data;
    logic [31:0] back_data;
    logic [6:0]  elem_count;
    logic [1:0]  status;

    int fail_count;
    int due_count;
    int idle_cycles = 0;
    int burst_left  = 1;
    int rx_cycle    = 0;
    int rx_mode     = 0;

    ring_buffer_deque DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .data_value (data_value),
        .elem_index (elem_index),
        .new_size   (new_size),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .front_data (front_data),
        .back_data  (back_data),
        .elem_count (elem_count),
        .status     (status)
    );

    ring_buffer_deque_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .data_value (data_value),
        .elem_index (elem_index),
        .new_size   (new_size),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .front_data (front_data),
        .back_data  (back_data),
        .elem_count (elem_count),
        .status     (status),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: always ready, random stalls, or a fixed duty pattern, switching every so often
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 150 == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (rx_cycle % 9) < 4;
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_word(rbd_pkg::req_t r, rbd_pkg::data_t d, logic [5:0] idx,
                             logic [6:0] nsz);
        req_type   <= r;
        data_value <= d;
        elem_index <= idx;
        new_size   <= nsz;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pace(bit last);
        burst_left--;
        if (last || burst_left <= 0)
        begin
            in_valid <= 1'b0;
            if (!last)
            begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 6);
            end
        end
    endtask

    task automatic issue(rbd_pkg::req_t r, rbd_pkg::data_t d, logic [5:0] idx,
                         logic [6:0] nsz);
        send_word(r, d, idx, nsz);
        pace(1'b0);
    endtask

    initial
    begin
        rbd_pkg::req_t  r;
        rbd_pkg::data_t d;
        logic [5:0]     idx;
        logic [6:0]     nsz;
        int             pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases, then pushes at both ends and reads in and out of range
        issue(rbd_pkg::REQ_POP_HEAD,   '0, '0, '0);
        issue(rbd_pkg::REQ_POP_BACK,   '0, '0, '0);
        issue(rbd_pkg::REQ_READ_INDEX, '0, '0, '0);
        issue(rbd_pkg::REQ_PUSH_REAR,  32'hFFFF_FFFF, '0, '0);
        issue(rbd_pkg::REQ_PUSH_FRONT, 32'h0000_0000, '0, '0);
        issue(rbd_pkg::REQ_PUSH_REAR,  32'h5A5A_A5A5, '0, '0);
        issue(rbd_pkg::REQ_READ_INDEX, '0, 6'd0, '0);
        issue(rbd_pkg::REQ_READ_INDEX, '0, 6'd1, '0);
        issue(rbd_pkg::REQ_READ_INDEX, '0, 6'd2, '0);
        issue(rbd_pkg::REQ_READ_INDEX, '0, 6'd3, '0);
        // oversize resize, then fill to full and push into it, then pops, shrinking resizes, clear and regrow
        issue(rbd_pkg::REQ_RESIZE,     32'h1234_5678, '0, 7'd127);
        issue(rbd_pkg::REQ_RESIZE,     32'h1234_5678, '0, 7'd65);
        issue(rbd_pkg::REQ_RESIZE,     32'hDEAD_BEEF, '0, 7'd64);
        issue(rbd_pkg::REQ_PUSH_REAR,  32'hAAAA_AAAA, '0, '0);
        issue(rbd_pkg::REQ_PUSH_FRONT, 32'h5555_5555, '0, '0);
        issue(rbd_pkg::REQ_READ_INDEX, '0, 6'd63, '0);
        issue(rbd_pkg::REQ_POP_BACK,   '0, '0, '0);
        issue(rbd_pkg::REQ_POP_HEAD,   '0, '0, '0);
        issue(rbd_pkg::REQ_RESIZE,     32'hFFFF_FFFF, '0, 7'd2);
        issue(rbd_pkg::REQ_NONE,       32'hFFFF_FFFF, 6'd63, 7'd127);
        issue(rbd_pkg::REQ_RESIZE,     '0, '0, 7'd0);
        issue(rbd_pkg::REQ_PUSH_FRONT, 32'h8000_0001, '0, '0);
        issue(rbd_pkg::REQ_CLEAR,      '0, '0, '0);
        issue(rbd_pkg::REQ_RESIZE,     32'h0F0F_F0F0, '0, 7'd3);
        issue(rbd_pkg::REQ_POP_HEAD,   '0, '0, '0);

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            pick = $urandom_range(0, 99);
            r = (pick < 20) ? rbd_pkg::REQ_PUSH_REAR  :
                (pick < 35) ? rbd_pkg::REQ_PUSH_FRONT :
                (pick < 50) ? rbd_pkg::REQ_POP_HEAD   :
                (pick < 62) ? rbd_pkg::REQ_POP_BACK   :
                (pick < 80) ? rbd_pkg::REQ_READ_INDEX :
                (pick < 83) ? rbd_pkg::REQ_CLEAR      :
                (pick < 96) ? rbd_pkg::REQ_RESIZE     : rbd_pkg::REQ_NONE;
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = '1;
                default: d = $urandom();
            endcase
            idx = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0:       nsz = 7'd64;
                1:       nsz = 7'($urandom_range(65, 127));
                default: nsz = 7'($urandom_range(0, 16));
            endcase
            send_word(r, d, idx, nsz);
            pace(k == RANDOM_WORDS - 1);
        end

        @(posedge clk);
        wait (due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* ring_buffer_deque.f */
design/rbd_pkg.sv
design/ring_buffer_deque.sv
tb/sv/ring_buffer_deque_checker.sv
tb/sv/ring_buffer_deque_tb.sv
